// File: hw/rtl/dpds_pkg.sv
// ============================================================================
// dpds_pkg
// Shared types, widths and constants for the dual PD drive slew controller.
// ============================================================================
package dpds_pkg;

    // Field widths.
    localparam int POS_W   = 24;   // encoder positions and targets
    localparam int GAIN_W  = 16;   // Q2.14 gains
    localparam int PCT_W   = 7;    // ramp percent, 0..100
    localparam int ERR_W   = 25;   // saturated loop error
    localparam int DER_W   = 26;   // error minus last error
    localparam int SLEW_W  = 16;   // slew values in mV
    localparam int DRIVE_W = 15;   // drive outputs in mV
    localparam int CFG_W   = 24;   // widest configuration register
    localparam int CFG_A_W = 3;    // eight registers

    // Controller constants.
    localparam int RAMP_STEP          = 10;
    localparam int RIGHT_TRIM_PERCENT = 96;
    localparam int GAIN_FRACTION_BITS = 14;
    localparam int PERCENT_FULL       = 100;
    localparam int DRIVE_LIMIT        = 12000;

    // Multiply-accumulate geometry: 4-bit digits, most significant first.
    localparam int DIGIT_W   = 4;
    localparam int PCT_SH_W  = 8;                      // percent padded to two digits
    localparam int ACC_W     = 44;                     // err*kp + der*kd
    localparam int PROD_W    = 52;                     // accumulator times percent
    localparam int MAG_W     = PROD_W - GAIN_FRACTION_BITS;
    localparam int GAIN_DIGS = GAIN_W / DIGIT_W;
    localparam int PCT_DIGS  = PCT_SH_W / DIGIT_W;

    // Divide-by-100 unit: 16 quotient bits, one per cycle.
    localparam int DIV_Q_W   = 16;
    localparam int DIV_R_W   = 7;
    localparam int DIV_IN_W  = DIV_Q_W + DIV_R_W;
    localparam int DIV_CNT_W = 5;

    // A slew magnitude at or above this saturates (quotient of 32768 or more).
    localparam longint SLEW_SAT_MAG = longint'(PERCENT_FULL) * 32768;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_TARGET_DISTANCE = 3'd0,
        CFG_TARGET_TURN     = 3'd1,
        CFG_LATERAL_KP      = 3'd2,
        CFG_LATERAL_KD      = 3'd3,
        CFG_TURN_KP         = 3'd4,
        CFG_TURN_KD         = 3'd5,
        CFG_SLEW_ENABLE     = 3'd6,
        CFG_TURN_MODE       = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAIR,
        ST_HALF,
        ST_DIFF,
        ST_ERR,
        ST_DER,
        ST_MAC_PD,
        ST_MAC_PCT,
        ST_ABS,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_RPREP,
        ST_RABS,
        ST_RDIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step_pd;
        logic step_pct;
    } t_mac_ctl;

    // Saturate a 26-bit error to the 25-bit signed range.
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [DER_W-1:0] v);
        logic signed [DER_W-1:0] hi;
        logic signed [DER_W-1:0] lo;
        hi = DER_W'((1 <<< (ERR_W - 1)) - 1);
        lo = -DER_W'(1 <<< (ERR_W - 1));
        if (v > hi) begin
            return ERR_W'(hi);
        end else if (v < lo) begin
            return ERR_W'(lo);
        end
        return ERR_W'(v);
    endfunction

endpackage

// File: hw/rtl/dpds_mac.sv
// ============================================================================
// dpds_mac
// Digit-serial multiply-accumulate: err*kp + der*kd, then times ramp percent.
// ============================================================================
module dpds_mac (
    input  logic                                  i_clk,
    input  dpds_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [dpds_pkg::ERR_W-1:0]     i_err,
    input  logic signed [dpds_pkg::DER_W-1:0]     i_der,
    input  logic        [dpds_pkg::GAIN_W-1:0]    i_kp,
    input  logic        [dpds_pkg::GAIN_W-1:0]    i_kd,
    input  logic        [dpds_pkg::PCT_W-1:0]     i_pct,
    output logic signed [dpds_pkg::PROD_W-1:0]    o_prod
);

    logic        [dpds_pkg::GAIN_W-1:0]   r_kp_sh;
    logic        [dpds_pkg::GAIN_W-1:0]   r_kd_sh;
    logic        [dpds_pkg::PCT_SH_W-1:0] r_pct_sh;
    logic signed [dpds_pkg::ACC_W-1:0]    r_acc;
    logic signed [dpds_pkg::PROD_W-1:0]   r_prod;

    logic signed [dpds_pkg::DIGIT_W:0]    w_kp_dig;
    logic signed [dpds_pkg::DIGIT_W:0]    w_kd_dig;
    logic signed [dpds_pkg::DIGIT_W:0]    w_pct_dig;
    logic signed [dpds_pkg::ACC_W-1:0]    w_pterm;
    logic signed [dpds_pkg::ACC_W-1:0]    w_dterm;
    logic signed [dpds_pkg::PROD_W-1:0]   w_rterm;

    // Digits are taken from the top of each shift register as an unsigned value.
    assign w_kp_dig  = $signed({1'b0, r_kp_sh[dpds_pkg::GAIN_W-1 -: dpds_pkg::DIGIT_W]});
    assign w_kd_dig  = $signed({1'b0, r_kd_sh[dpds_pkg::GAIN_W-1 -: dpds_pkg::DIGIT_W]});
    assign w_pct_dig = $signed({1'b0, r_pct_sh[dpds_pkg::PCT_SH_W-1 -: dpds_pkg::DIGIT_W]});

    assign w_pterm = dpds_pkg::ACC_W'(i_err) * dpds_pkg::ACC_W'(w_kp_dig);
    assign w_dterm = dpds_pkg::ACC_W'(i_der) * dpds_pkg::ACC_W'(w_kd_dig);
    assign w_rterm = dpds_pkg::PROD_W'(r_acc) * dpds_pkg::PROD_W'(w_pct_dig);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_kp_sh  <= i_kp;
            r_kd_sh  <= i_kd;
            r_pct_sh <= dpds_pkg::PCT_SH_W'(i_pct);
            r_acc    <= '0;
            r_prod   <= '0;
        end else if (i_ctl.step_pd) begin
            r_kp_sh <= r_kp_sh << dpds_pkg::DIGIT_W;
            r_kd_sh <= r_kd_sh << dpds_pkg::DIGIT_W;
            r_acc   <= (r_acc <<< dpds_pkg::DIGIT_W) + w_pterm + w_dterm;
        end else if (i_ctl.step_pct) begin
            r_pct_sh <= r_pct_sh << dpds_pkg::DIGIT_W;
            r_prod   <= (r_prod <<< dpds_pkg::DIGIT_W) + w_rterm;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/dpds_div.sv
// ============================================================================
// dpds_div
// Bit-serial restoring divider by 100, one quotient bit per cycle.
// ============================================================================
module dpds_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [dpds_pkg::DIV_IN_W-1:0]     i_dividend,
    output logic                              o_busy,
    output logic [dpds_pkg::DIV_Q_W-1:0]      o_quot
);

    logic                              r_busy;
    logic [dpds_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [dpds_pkg::DIV_R_W-1:0]      r_rem;
    logic [dpds_pkg::DIV_Q_W-1:0]      r_dsh;
    logic [dpds_pkg::DIV_Q_W-1:0]      r_quot;

    logic [dpds_pkg::DIV_R_W:0]        w_trial;
    logic                              w_ge;

    assign w_trial = {r_rem, r_dsh[dpds_pkg::DIV_Q_W-1]};
    assign w_ge    = (w_trial >= (dpds_pkg::DIV_R_W + 1)'(dpds_pkg::PERCENT_FULL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= dpds_pkg::DIV_CNT_W'(dpds_pkg::DIV_Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - dpds_pkg::DIV_CNT_W'(1);
            if (r_cnt == dpds_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The upper dividend bits are always below 100, so they seed the remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[dpds_pkg::DIV_IN_W-1 -: dpds_pkg::DIV_R_W];
            r_dsh  <= i_dividend[dpds_pkg::DIV_Q_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= dpds_pkg::DIV_R_W'(w_trial
                         - (dpds_pkg::DIV_R_W + 1)'(dpds_pkg::PERCENT_FULL));
            end else begin
                r_rem <= w_trial[dpds_pkg::DIV_R_W-1:0];
            end
            r_dsh  <= r_dsh << 1;
            r_quot <= {r_quot[dpds_pkg::DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/dual_pd_drive_slew_controller.sv
// ============================================================================
// dual_pd_drive_slew_controller
// Two PD loops on averaged encoder positions with a ramped slew output.
// ============================================================================
// One transaction at a time; the next one is taken in the cycle after the
// result is registered. The bit-serial divide by 100, used for the slew value when
// slew is enabled and for the right trim in every transaction, and the 4-bit
// digit multiply-add, used only with slew enabled, take up most of the sequence.
// Synchronous active-low reset restores register defaults and clears the
// sequencer, the divider, the loop state and the output valid flag.
module dual_pd_drive_slew_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [dpds_pkg::CFG_A_W-1:0]    i_cfg_addr,
    input  logic        [dpds_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [dpds_pkg::POS_W-1:0]      i_left_front_pos,
    input  logic signed [dpds_pkg::POS_W-1:0]      i_left_rear_pos,
    input  logic signed [dpds_pkg::POS_W-1:0]      i_right_front_pos,
    input  logic signed [dpds_pkg::POS_W-1:0]      i_right_rear_pos,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [dpds_pkg::DRIVE_W-1:0]    o_left_drive,
    output logic signed [dpds_pkg::DRIVE_W-1:0]    o_right_drive
);

    // Configuration registers.
    logic signed [dpds_pkg::POS_W-1:0]   r_target_distance;
    logic signed [dpds_pkg::POS_W-1:0]   r_target_turn;
    logic        [dpds_pkg::GAIN_W-1:0]  r_lateral_kp;
    logic        [dpds_pkg::GAIN_W-1:0]  r_lateral_kd;
    logic        [dpds_pkg::GAIN_W-1:0]  r_turn_kp;
    logic        [dpds_pkg::GAIN_W-1:0]  r_turn_kd;
    logic                                r_slew_enable;
    logic                                r_turn_mode;

    // Loop state.
    logic signed [dpds_pkg::ERR_W-1:0]   r_last_lat_err;
    logic signed [dpds_pkg::ERR_W-1:0]   r_last_trn_err;
    logic        [dpds_pkg::PCT_W-1:0]   r_lat_ramp;
    logic        [dpds_pkg::PCT_W-1:0]   r_trn_ramp;
    logic signed [dpds_pkg::SLEW_W-1:0]  r_lat_slew;
    logic signed [dpds_pkg::SLEW_W-1:0]  r_trn_slew;

    // Datapath registers.
    dpds_pkg::t_state                    r_state;
    dpds_pkg::t_state                    n_state;
    logic signed [dpds_pkg::POS_W-1:0]   r_lf;
    logic signed [dpds_pkg::POS_W-1:0]   r_lr;
    logic signed [dpds_pkg::POS_W-1:0]   r_rf;
    logic signed [dpds_pkg::POS_W-1:0]   r_rr;
    logic signed [dpds_pkg::POS_W:0]     r_ls;
    logic signed [dpds_pkg::POS_W:0]     r_rs;
    logic signed [dpds_pkg::POS_W+1:0]   r_quad;
    logic signed [dpds_pkg::POS_W-1:0]   r_lh;
    logic signed [dpds_pkg::POS_W-1:0]   r_rh;
    logic signed [dpds_pkg::POS_W-1:0]   r_avg;
    logic signed [dpds_pkg::POS_W:0]     r_diff;
    logic signed [dpds_pkg::ERR_W-1:0]   r_lat_err;
    logic signed [dpds_pkg::ERR_W-1:0]   r_trn_err;
    logic signed [dpds_pkg::ERR_W-1:0]   r_err;
    logic signed [dpds_pkg::DER_W-1:0]   r_der;
    logic        [1:0]                   r_dig;
    logic                                r_neg;
    logic                                r_sat;
    logic        [dpds_pkg::PROD_W-1:0]  r_mag;
    logic signed [dpds_pkg::POS_W-1:0]   r_rprod;
    logic        [dpds_pkg::DIV_Q_W-1:0] r_rq;
    logic                                r_out_valid;
    logic signed [dpds_pkg::DRIVE_W-1:0] r_left_drive;
    logic signed [dpds_pkg::DRIVE_W-1:0] r_right_drive;

    // Combinational signals.
    dpds_pkg::t_mac_ctl                  w_mac_ctl;
    logic                                w_div_start;
    logic        [dpds_pkg::DIV_IN_W-1:0] w_dividend;
    logic                                w_div_busy;
    logic        [dpds_pkg::DIV_Q_W-1:0] w_quot;
    logic signed [dpds_pkg::PROD_W-1:0]  w_prod;
    logic signed [dpds_pkg::POS_W+1:0]   w_quad_b;
    logic signed [dpds_pkg::DER_W-1:0]   w_lat_raw;
    logic signed [dpds_pkg::DER_W-1:0]   w_trn_raw;
    logic signed [dpds_pkg::ERR_W-1:0]   w_err_sel;
    logic signed [dpds_pkg::ERR_W-1:0]   w_last_sel;
    logic        [dpds_pkg::MAG_W-1:0]   w_mag_sh;
    logic signed [dpds_pkg::SLEW_W-1:0]  w_slew;
    logic signed [dpds_pkg::SLEW_W:0]    w_sdiff;
    logic signed [dpds_pkg::SLEW_W:0]    w_ssum;
    logic        [dpds_pkg::DIV_Q_W-1:0] w_rmag;
    logic        [dpds_pkg::PCT_W:0]     w_ramp_src;
    logic        [dpds_pkg::PCT_W:0]     w_ramp_inc;
    logic        [dpds_pkg::PCT_W-1:0]   w_ramp_next;
    logic                                w_out_free;

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_distance <= '0;
            r_target_turn     <= '0;
            r_lateral_kp      <= dpds_pkg::GAIN_W'(1475);
            r_lateral_kd      <= dpds_pkg::GAIN_W'(1475);
            r_turn_kp         <= dpds_pkg::GAIN_W'(754);
            r_turn_kd         <= dpds_pkg::GAIN_W'(819);
            r_slew_enable     <= 1'b0;
            r_turn_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (dpds_pkg::t_cfg_idx'(i_cfg_addr))
                dpds_pkg::CFG_TARGET_DISTANCE: r_target_distance <= $signed(i_cfg_data);
                dpds_pkg::CFG_TARGET_TURN:     r_target_turn     <= $signed(i_cfg_data);
                dpds_pkg::CFG_LATERAL_KP:      r_lateral_kp <= i_cfg_data[dpds_pkg::GAIN_W-1:0];
                dpds_pkg::CFG_LATERAL_KD:      r_lateral_kd <= i_cfg_data[dpds_pkg::GAIN_W-1:0];
                dpds_pkg::CFG_TURN_KP:         r_turn_kp    <= i_cfg_data[dpds_pkg::GAIN_W-1:0];
                dpds_pkg::CFG_TURN_KD:         r_turn_kd    <= i_cfg_data[dpds_pkg::GAIN_W-1:0];
                dpds_pkg::CFG_SLEW_ENABLE:     r_slew_enable <= i_cfg_data[0];
                dpds_pkg::CFG_TURN_MODE:       r_turn_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------------
    dpds_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_err  (r_err),
        .i_der  (r_der),
        .i_kp   (r_turn_mode ? r_turn_kp : r_lateral_kp),
        .i_kd   (r_turn_mode ? r_turn_kd : r_lateral_kd),
        .i_pct  (r_turn_mode ? r_trn_ramp : r_lat_ramp),
        .o_prod (w_prod)
    );

    dpds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // ------------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------------
    // Division by four truncates toward zero, so negative sums get a bias.
    assign w_quad_b  = r_quad + (r_quad[dpds_pkg::POS_W+1] ? (dpds_pkg::POS_W + 2)'(3)
                                                           : (dpds_pkg::POS_W + 2)'(0));
    assign w_lat_raw = dpds_pkg::DER_W'(r_target_distance) - dpds_pkg::DER_W'(r_avg);
    assign w_trn_raw = dpds_pkg::DER_W'(r_target_turn) - dpds_pkg::DER_W'(r_diff);
    assign w_err_sel  = r_turn_mode ? r_trn_err : r_lat_err;
    assign w_last_sel = r_turn_mode ? r_last_trn_err : r_last_lat_err;
    assign w_mag_sh   = r_mag[dpds_pkg::PROD_W-1:dpds_pkg::GAIN_FRACTION_BITS];

    always_comb begin
        if (r_sat) begin
            w_slew = r_neg ? $signed({1'b1, {(dpds_pkg::SLEW_W-1){1'b0}}})
                           : $signed({1'b0, {(dpds_pkg::SLEW_W-1){1'b1}}});
        end else if (r_neg) begin
            w_slew = $signed(-w_quot);
        end else begin
            w_slew = $signed(w_quot);
        end
    end

    assign w_ramp_src  = {1'b0, r_turn_mode ? r_trn_ramp : r_lat_ramp};
    assign w_ramp_inc  = w_ramp_src + (dpds_pkg::PCT_W + 1)'(dpds_pkg::RAMP_STEP);
    assign w_ramp_next = (w_ramp_inc > (dpds_pkg::PCT_W + 1)'(dpds_pkg::PERCENT_FULL))
                         ? dpds_pkg::PCT_W'(dpds_pkg::PERCENT_FULL)
                         : w_ramp_inc[dpds_pkg::PCT_W-1:0];

    assign w_sdiff = (dpds_pkg::SLEW_W + 1)'(r_lat_slew) - (dpds_pkg::SLEW_W + 1)'(r_trn_slew);
    assign w_ssum  = (dpds_pkg::SLEW_W + 1)'(r_lat_slew) + (dpds_pkg::SLEW_W + 1)'(r_trn_slew);
    assign w_rmag  = (r_rq > dpds_pkg::DIV_Q_W'(dpds_pkg::DRIVE_LIMIT))
                     ? dpds_pkg::DIV_Q_W'(dpds_pkg::DRIVE_LIMIT) : r_rq;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_state == dpds_pkg::ST_RABS) begin
            w_dividend = r_rprod[dpds_pkg::POS_W-1] ? dpds_pkg::DIV_IN_W'(-r_rprod)
                                                    : dpds_pkg::DIV_IN_W'(r_rprod);
        end else begin
            w_dividend = w_mag_sh[dpds_pkg::DIV_IN_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mac_ctl   = '0;
        w_div_start = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            dpds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = dpds_pkg::ST_PAIR;
                end
            end
            dpds_pkg::ST_PAIR: n_state = dpds_pkg::ST_HALF;
            dpds_pkg::ST_HALF: n_state = dpds_pkg::ST_DIFF;
            dpds_pkg::ST_DIFF: n_state = dpds_pkg::ST_ERR;
            dpds_pkg::ST_ERR:  n_state = dpds_pkg::ST_DER;
            dpds_pkg::ST_DER: begin
                w_mac_ctl.load = 1'b1;
                n_state = r_slew_enable ? dpds_pkg::ST_MAC_PD : dpds_pkg::ST_RPREP;
            end
            dpds_pkg::ST_MAC_PD: begin
                w_mac_ctl.step_pd = 1'b1;
                if (r_dig == 2'd0) begin
                    n_state = dpds_pkg::ST_MAC_PCT;
                end
            end
            dpds_pkg::ST_MAC_PCT: begin
                w_mac_ctl.step_pct = 1'b1;
                if (r_dig == 2'd0) begin
                    n_state = dpds_pkg::ST_ABS;
                end
            end
            dpds_pkg::ST_ABS: n_state = dpds_pkg::ST_SDIV_GO;
            dpds_pkg::ST_SDIV_GO: begin
                w_div_start = 1'b1;
                n_state     = dpds_pkg::ST_SDIV_WAIT;
            end
            dpds_pkg::ST_SDIV_WAIT: begin
                if (!w_div_busy) begin
                    n_state = dpds_pkg::ST_RPREP;
                end
            end
            dpds_pkg::ST_RPREP: n_state = dpds_pkg::ST_RABS;
            dpds_pkg::ST_RABS: begin
                w_div_start = 1'b1;
                n_state     = dpds_pkg::ST_RDIV_WAIT;
            end
            dpds_pkg::ST_RDIV_WAIT: begin
                if (!w_div_busy) begin
                    n_state = dpds_pkg::ST_OUT;
                end
            end
            dpds_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = dpds_pkg::ST_IDLE;
                end
            end
            default: n_state = dpds_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dpds_pkg::ST_IDLE: begin
                r_lf <= i_left_front_pos;
                r_lr <= i_left_rear_pos;
                r_rf <= i_right_front_pos;
                r_rr <= i_right_rear_pos;
            end
            dpds_pkg::ST_PAIR: begin
                r_ls <= (dpds_pkg::POS_W + 1)'(r_lf) + (dpds_pkg::POS_W + 1)'(r_lr);
                r_rs <= (dpds_pkg::POS_W + 1)'(r_rf) + (dpds_pkg::POS_W + 1)'(r_rr);
            end
            dpds_pkg::ST_HALF: begin
                // Halving a pair truncates toward zero: add the sign bit first.
                r_quad <= (dpds_pkg::POS_W + 2)'(r_ls) + (dpds_pkg::POS_W + 2)'(r_rs);
                r_lh   <= dpds_pkg::POS_W'((r_ls + (dpds_pkg::POS_W + 1)'(r_ls[dpds_pkg::POS_W]))
                                           >>> 1);
                r_rh   <= dpds_pkg::POS_W'((r_rs + (dpds_pkg::POS_W + 1)'(r_rs[dpds_pkg::POS_W]))
                                           >>> 1);
            end
            dpds_pkg::ST_DIFF: begin
                r_avg  <= w_quad_b[dpds_pkg::POS_W+1:2];
                r_diff <= (dpds_pkg::POS_W + 1)'(r_lh) - (dpds_pkg::POS_W + 1)'(r_rh);
            end
            dpds_pkg::ST_ERR: begin
                r_lat_err <= dpds_pkg::sat_err(w_lat_raw);
                r_trn_err <= dpds_pkg::sat_err(w_trn_raw);
            end
            dpds_pkg::ST_DER: begin
                r_err <= w_err_sel;
                r_der <= dpds_pkg::DER_W'(w_err_sel) - dpds_pkg::DER_W'(w_last_sel);
                r_dig <= 2'(dpds_pkg::GAIN_DIGS - 1);
            end
            dpds_pkg::ST_MAC_PD: begin
                r_dig <= (r_dig == 2'd0) ? 2'(dpds_pkg::PCT_DIGS - 1) : r_dig - 2'd1;
            end
            dpds_pkg::ST_MAC_PCT: begin
                r_dig <= r_dig - 2'd1;
            end
            dpds_pkg::ST_ABS: begin
                r_neg <= w_prod[dpds_pkg::PROD_W-1];
                r_mag <= w_prod[dpds_pkg::PROD_W-1] ? dpds_pkg::PROD_W'(-w_prod)
                                                    : dpds_pkg::PROD_W'(w_prod);
            end
            dpds_pkg::ST_SDIV_GO: begin
                r_sat <= (w_mag_sh >= dpds_pkg::MAG_W'(dpds_pkg::SLEW_SAT_MAG));
            end
            dpds_pkg::ST_RPREP: begin
                r_rprod <= dpds_pkg::POS_W'(w_sdiff)
                           * dpds_pkg::POS_W'(dpds_pkg::RIGHT_TRIM_PERCENT);
            end
            dpds_pkg::ST_RABS: begin
                r_neg <= r_rprod[dpds_pkg::POS_W-1];
            end
            dpds_pkg::ST_RDIV_WAIT: begin
                r_rq <= w_quot;
            end
            default: ;
        endcase
    end

    // Loop state: errors update every transaction, slew and ramp only when enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lat_err <= '0;
            r_last_trn_err <= '0;
            r_lat_ramp     <= '0;
            r_trn_ramp     <= '0;
            r_lat_slew     <= '0;
            r_trn_slew     <= '0;
        end else begin
            if (r_state == dpds_pkg::ST_DER) begin
                r_last_lat_err <= r_lat_err;
                r_last_trn_err <= r_trn_err;
            end
            if (r_state == dpds_pkg::ST_SDIV_WAIT && !w_div_busy) begin
                if (r_turn_mode) begin
                    r_trn_slew <= w_slew;
                    r_trn_ramp <= w_ramp_next;
                end else begin
                    r_lat_slew <= w_slew;
                    r_lat_ramp <= w_ramp_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dpds_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dpds_pkg::ST_OUT && w_out_free) begin
            if (w_ssum > (dpds_pkg::SLEW_W + 1)'(dpds_pkg::DRIVE_LIMIT)) begin
                r_left_drive <= dpds_pkg::DRIVE_W'(dpds_pkg::DRIVE_LIMIT);
            end else if (w_ssum < -(dpds_pkg::SLEW_W + 1)'(dpds_pkg::DRIVE_LIMIT)) begin
                r_left_drive <= -dpds_pkg::DRIVE_W'(dpds_pkg::DRIVE_LIMIT);
            end else begin
                r_left_drive <= dpds_pkg::DRIVE_W'(w_ssum);
            end
            r_right_drive <= r_neg ? $signed(-dpds_pkg::DRIVE_W'(w_rmag))
                                   : $signed(dpds_pkg::DRIVE_W'(w_rmag));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the dual PD drive slew controller
// Four encoder positions go in on a valid/ready channel and two saturated
// drive voltages come back. A behavioral model of both PD loops, the slew
// ramps and the right trim predicts each result. Directed ticks hit the
// extremes and the special cases, then random phases of traffic follow, each
// with its own register settings, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import dpds_pkg::*;

    localparam longint P_MAX       = 8388607;
    localparam longint P_MIN       = -8388608;
    localparam longint ERR_HI      = 16777215;
    localparam longint ERR_LO      = -16777216;
    localparam longint RAMP_INC    = 10;
    localparam longint RAMP_TOP    = 100;
    localparam longint TRIM_PCT    = 96;
    localparam longint FRAC_BITS   = 14;
    localparam longint DRIVE_MAX   = 12000;
    localparam int     RANDOM_TICKS = 500;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     END_CYCLES    = 100;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } t_drive;

    typedef enum bit {ROW_CFG, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_cfg_idx                reg_idx;
        logic [CFG_W-1:0]        reg_data;
        logic signed [POS_W-1:0] lf;
        logic signed [POS_W-1:0] lr;
        logic signed [POS_W-1:0] rf;
        logic signed [POS_W-1:0] rr;
        bit                      has_exp;
        t_drive                  exp_drive;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_A_W-1:0]        i_cfg_addr;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [POS_W-1:0]   i_left_front_pos;
    logic signed [POS_W-1:0]   i_left_rear_pos;
    logic signed [POS_W-1:0]   i_right_front_pos;
    logic signed [POS_W-1:0]   i_right_rear_pos;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [DRIVE_W-1:0] o_left_drive;
    logic signed [DRIVE_W-1:0] o_right_drive;

    // Register mirror, at reset defaults.
    longint reg_target_distance = 0;
    longint reg_target_turn     = 0;
    longint reg_lat_kp          = 1475;
    longint reg_lat_kd          = 1475;
    longint reg_trn_kp          = 754;
    longint reg_trn_kd          = 819;
    bit     reg_slew_en         = 1'b0;
    bit     reg_turn_sel        = 1'b0;

    // Loop state of the model.
    longint last_lat_err = 0;
    longint last_trn_err = 0;
    longint lat_pct      = 0;
    longint trn_pct      = 0;
    longint lat_slew_mv  = 0;
    longint trn_slew_mv  = 0;

    t_drive    drive_expect_q[$];
    t_stim_row stim_rows[$];
    int        mismatch_count = 0;
    bit        quiet = 1'b0;

    dual_pd_drive_slew_controller uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_left_front_pos  (i_left_front_pos),
        .i_left_rear_pos   (i_left_rear_pos),
        .i_right_front_pos (i_right_front_pos),
        .i_right_rear_pos  (i_right_rear_pos),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_drive      (o_left_drive),
        .o_right_drive     (o_right_drive)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint ramped_power(longint err, longint der, longint kp, longint kd,
                                            longint pct);
        longint acc;
        acc = err * kp + der * kd;
        return clamp_range((acc * pct) / (RAMP_TOP * (longint'(1) << FRAC_BITS)),
                           -32768, 32767);
    endfunction

    // Advances the loop state by one tick and returns the drive pair.
    function automatic t_drive step_drives(logic signed [POS_W-1:0] lf,
                                           logic signed [POS_W-1:0] lr,
                                           logic signed [POS_W-1:0] rf,
                                           logic signed [POS_W-1:0] rr);
        longint avg;
        longint diff;
        longint lat_err;
        longint trn_err;
        longint left;
        longint right;
        t_drive d;
        avg = (longint'(lf) + longint'(lr) + longint'(rf) + longint'(rr)) / 4;
        lat_err = clamp_range(reg_target_distance - avg, ERR_LO, ERR_HI);
        diff = (longint'(lf) + longint'(lr)) / 2 - (longint'(rf) + longint'(rr)) / 2;
        trn_err = clamp_range(reg_target_turn - diff, ERR_LO, ERR_HI);
        if (reg_slew_en) begin
            if (!reg_turn_sel) begin
                lat_slew_mv = ramped_power(lat_err, lat_err - last_lat_err, reg_lat_kp,
                                           reg_lat_kd, lat_pct);
                lat_pct = (lat_pct + RAMP_INC > RAMP_TOP) ? RAMP_TOP : lat_pct + RAMP_INC;
            end else begin
                trn_slew_mv = ramped_power(trn_err, trn_err - last_trn_err, reg_trn_kp,
                                           reg_trn_kd, trn_pct);
                trn_pct = (trn_pct + RAMP_INC > RAMP_TOP) ? RAMP_TOP : trn_pct + RAMP_INC;
            end
        end
        left = clamp_range(lat_slew_mv + trn_slew_mv, -DRIVE_MAX, DRIVE_MAX);
        right = clamp_range(((lat_slew_mv - trn_slew_mv) * TRIM_PCT) / 100,
                            -DRIVE_MAX, DRIVE_MAX);
        last_lat_err = lat_err;
        last_trn_err = trn_err;
        d.left = DRIVE_W'(left);
        d.right = DRIVE_W'(right);
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_stim_row cfg_row(t_cfg_idx idx, longint data);
        t_stim_row r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_data = CFG_W'(data);
        r.lf = '0;
        r.lr = '0;
        r.rf = '0;
        r.rr = '0;
        r.has_exp = 1'b0;
        r.exp_drive = '0;
        return r;
    endfunction

    function automatic t_stim_row tick_row(longint lf, longint lr, longint rf, longint rr,
                                           bit has_exp = 1'b0, longint exp_l = 0,
                                           longint exp_r = 0);
        t_stim_row r;
        r.kind = ROW_TICK;
        r.reg_idx = CFG_TARGET_DISTANCE;
        r.reg_data = '0;
        r.lf = POS_W'(lf);
        r.lr = POS_W'(lr);
        r.rf = POS_W'(rf);
        r.rr = POS_W'(rr);
        r.has_exp = has_exp;
        r.exp_drive.left = DRIVE_W'(exp_l);
        r.exp_drive.right = DRIVE_W'(exp_r);
        return r;
    endfunction

    function automatic int unsigned source_gap();
        int unsigned r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [CFG_W-1:0] rand_target();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(P_MAX);
            1:       return CFG_W'(P_MIN);
            2, 3:    return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(16'hFFFF);
            2, 3:    return CFG_W'($urandom_range(0, 4095));
            4:       return CFG_W'(1475);
            default: return CFG_W'(16'($urandom));
        endcase
    endfunction

    function automatic longint edge_pos();
        case ($urandom_range(0, 4))
            0:       return P_MAX;
            1:       return P_MIN;
            2:       return 0;
            3:       return -1;
            default: return longint'(POS_W'($urandom));
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        logic signed [POS_W-1:0] sdata;
        sdata = data[POS_W-1:0];
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TARGET_DISTANCE: reg_target_distance = longint'(sdata);
            CFG_TARGET_TURN:     reg_target_turn = longint'(sdata);
            CFG_LATERAL_KP:      reg_lat_kp = longint'(data[GAIN_W-1:0]);
            CFG_LATERAL_KD:      reg_lat_kd = longint'(data[GAIN_W-1:0]);
            CFG_TURN_KP:         reg_trn_kp = longint'(data[GAIN_W-1:0]);
            CFG_TURN_KD:         reg_trn_kd = longint'(data[GAIN_W-1:0]);
            CFG_SLEW_ENABLE:     reg_slew_en = data[0];
            CFG_TURN_MODE:       reg_turn_sel = data[0];
            default: ;
        endcase
    endtask

    // Waits until every pending transaction has produced its result.
    task automatic drain_pipeline();
        i_in_valid = 1'b0;
        while (drive_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Entered and left at a falling edge; valid stays high on return so that a
    // back-to-back transaction keeps it up without a glitch.
    task automatic send_tick(logic signed [POS_W-1:0] lf, logic signed [POS_W-1:0] lr,
                             logic signed [POS_W-1:0] rf, logic signed [POS_W-1:0] rr,
                             bit has_exp, t_drive typed);
        int unsigned gap;
        t_drive pred;
        gap = source_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_left_front_pos = lf;
        i_left_rear_pos = lr;
        i_right_front_pos = rf;
        i_right_rear_pos = rr;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = step_drives(lf, lr, rf, rr);
        drive_expect_q.push_back(has_exp ? typed : pred);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned r;
        int unsigned n;
        i_out_ready = 1'b0;
        forever begin
            if (quiet) begin
                i_out_ready = 1'b1;
                @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready = 1'b1;
                    n = $urandom_range(1, 12);
                end else if (r < 90) begin
                    i_out_ready = 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_ready = 1'b0;
                    n = $urandom_range(8, 40);
                end
                repeat (n) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_drive want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result left %0d right %0d",
                                          o_left_drive, o_right_drive));
            end else begin
                want = drive_expect_q.pop_front();
                if (o_left_drive !== want.left) begin
                    report_mismatch($sformatf("left_drive got %0d expected %0d",
                                              o_left_drive, $signed(want.left)));
                end
                if (o_right_drive !== want.right) begin
                    report_mismatch($sformatf("right_drive got %0d expected %0d",
                                              o_right_drive, $signed(want.right)));
                end
            end
        end
    end

    initial begin
        t_stim_row   row;
        int unsigned rand_ticks;
        int unsigned phase_len;
        int unsigned r;
        longint      noise_amp;
        longint      half_turn;
        longint      pos [4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_TARGET_DISTANCE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_left_front_pos = '0;
        i_left_rear_pos = '0;
        i_right_front_pos = '0;
        i_right_rear_pos = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Slew disabled out of reset: drives hold at zero.
        stim_rows.push_back(tick_row(0, 0, 0, 0, 1'b1, 0, 0));
        stim_rows.push_back(tick_row(P_MAX, P_MAX, P_MAX, P_MAX, 1'b1, 0, 0));
        stim_rows.push_back(tick_row(P_MIN, P_MIN, P_MAX, P_MAX, 1'b1, 0, 0));
        // Turn ramp with full gains; the second tick saturates the turn error.
        stim_rows.push_back(cfg_row(CFG_TURN_KP, 65535));
        stim_rows.push_back(cfg_row(CFG_TURN_KD, 65535));
        stim_rows.push_back(cfg_row(CFG_TARGET_TURN, P_MAX));
        stim_rows.push_back(cfg_row(CFG_TURN_MODE, 1));
        stim_rows.push_back(cfg_row(CFG_SLEW_ENABLE, 1));
        stim_rows.push_back(tick_row(0, 0, 0, 0, 1'b1, 0, 0));
        stim_rows.push_back(tick_row(P_MIN, P_MIN, P_MAX, P_MAX, 1'b1, 12000, -12000));
        stim_rows.push_back(tick_row(1000, -2000, 3500, 70, 1'b0));
        stim_rows.push_back(tick_row(8388000, 8388100, -8388000, -8388100, 1'b0));
        stim_rows.push_back(tick_row(P_MAX, P_MAX, P_MIN, P_MIN, 1'b0));
        stim_rows.push_back(tick_row(P_MAX, P_MAX, P_MIN, P_MIN, 1'b1, -12000, 12000));
        // Lateral ramp; the turn slew value is held at negative full scale.
        stim_rows.push_back(cfg_row(CFG_TURN_MODE, 0));
        stim_rows.push_back(cfg_row(CFG_LATERAL_KP, 65535));
        stim_rows.push_back(cfg_row(CFG_LATERAL_KD, 65535));
        stim_rows.push_back(cfg_row(CFG_TARGET_DISTANCE, P_MIN));
        stim_rows.push_back(tick_row(P_MAX, P_MAX, P_MAX, P_MAX, 1'b1, -12000, 12000));
        stim_rows.push_back(tick_row(P_MAX, P_MAX, P_MAX, P_MAX, 1'b1, -12000, 0));
        // With slew disabled both slew values hold, whatever the positions.
        stim_rows.push_back(cfg_row(CFG_SLEW_ENABLE, 0));
        stim_rows.push_back(tick_row(0, 0, 0, 0, 1'b1, -12000, 0));
        stim_rows.push_back(tick_row(-5, 123456, P_MIN, 77, 1'b1, -12000, 0));
        stim_rows.push_back(cfg_row(CFG_SLEW_ENABLE, 1));
        stim_rows.push_back(tick_row(-8388000, -8388500, -8388300, -8388200, 1'b0));
        stim_rows.push_back(tick_row(-8300000, -8350000, -8380000, -8388600, 1'b0));
        // Zero gains force the ramped value to zero.
        stim_rows.push_back(cfg_row(CFG_LATERAL_KP, 0));
        stim_rows.push_back(cfg_row(CFG_LATERAL_KD, 0));
        stim_rows.push_back(cfg_row(CFG_TURN_KP, 0));
        stim_rows.push_back(cfg_row(CFG_TURN_KD, 0));
        stim_rows.push_back(tick_row(42, -42, 4242, -4242, 1'b1, -12000, 12000));
        stim_rows.push_back(cfg_row(CFG_TURN_MODE, 1));
        stim_rows.push_back(tick_row(P_MAX, P_MIN, -1, 1, 1'b1, 0, 0));

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_tick(row.lf, row.lr, row.rf, row.rr, row.has_exp, row.exp_drive);
            end
        end

        // Random phases: new settings each phase, positions mostly near the targets.
        rand_ticks = 0;
        while (rand_ticks < RANDOM_TICKS) begin
            drain_pipeline();
            write_reg(CFG_TARGET_DISTANCE, rand_target());
            write_reg(CFG_TARGET_TURN, rand_target());
            write_reg(CFG_LATERAL_KP, rand_gain());
            write_reg(CFG_LATERAL_KD, rand_gain());
            write_reg(CFG_TURN_KP, rand_gain());
            write_reg(CFG_TURN_KD, rand_gain());
            write_reg(CFG_SLEW_ENABLE, CFG_W'($urandom_range(0, 99) < 85));
            write_reg(CFG_TURN_MODE, CFG_W'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(12, 40);
            case ($urandom_range(0, 2))
                0:       noise_amp = 16;
                1:       noise_amp = 600;
                default: noise_amp = 40000;
            endcase
            half_turn = reg_target_turn / 2;
            for (int k = 0; k < phase_len && rand_ticks < RANDOM_TICKS; k++) begin
                r = $urandom_range(0, 99);
                for (int w = 0; w < 4; w++) begin
                    if (r < 70) begin
                        pos[w] = reg_target_distance + ((w < 2) ? half_turn : -half_turn)
                                 + longint'($urandom_range(0, 32'(2 * noise_amp)))
                                 - noise_amp;
                    end else if (r < 85) begin
                        pos[w] = longint'(POS_W'($urandom));
                    end else begin
                        pos[w] = edge_pos();
                    end
                end
                send_tick(POS_W'(pos[0]), POS_W'(pos[1]), POS_W'(pos[2]), POS_W'(pos[3]),
                          1'b0, '0);
                rand_ticks++;
            end
        end

        i_in_valid = 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
